// ===== src/bse_pkg.sv =====
package bse_pkg;

    // special codes
    localparam logic [4:0] CODE_LF    = 5'd2;
    localparam logic [4:0] CODE_SPACE = 5'd4;
    localparam logic [4:0] CODE_CR    = 5'd8;
    localparam logic [4:0] CODE_FIGS  = 5'd27;
    localparam logic [4:0] CODE_LTRS  = 5'd31;

    // case values
    localparam logic CASE_LTRS = 1'b0;
    localparam logic CASE_FIGS = 1'b1;

    // configuration register indexes
    localparam logic CFG_FIGURES_SET = 1'b0;
    localparam logic CFG_START_SHIFT = 1'b1;

    // output queue depth and pointer widths
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_look;

    typedef struct packed {
        logic [4:0] code;
        logic       last;
        logic       shift_after;
    } t_res;

    // up to two codes written into the output queue at once
    typedef struct packed {
        logic valid;
        logic two;
        t_res first;
        t_res second;
    } t_push;

    // letters table, inverted: ascii to code
    function automatic t_look find_letter(input logic [7:0] ch);
        t_look r;
        r.hit  = 1'b1;
        r.code = 5'd0;
        case (ch)
            8'h45: r.code = 5'd1;   // E
            8'h0A: r.code = 5'd2;   // line feed
            8'h41: r.code = 5'd3;   // A
            8'h20: r.code = 5'd4;   // space
            8'h53: r.code = 5'd5;   // S
            8'h49: r.code = 5'd6;   // I
            8'h55: r.code = 5'd7;   // U
            8'h0D: r.code = 5'd8;   // carriage return
            8'h44: r.code = 5'd9;   // D
            8'h52: r.code = 5'd10;  // R
            8'h4A: r.code = 5'd11;  // J
            8'h4E: r.code = 5'd12;  // N
            8'h46: r.code = 5'd13;  // F
            8'h43: r.code = 5'd14;  // C
            8'h4B: r.code = 5'd15;  // K
            8'h54: r.code = 5'd16;  // T
            8'h5A: r.code = 5'd17;  // Z
            8'h4C: r.code = 5'd18;  // L
            8'h57: r.code = 5'd19;  // W
            8'h48: r.code = 5'd20;  // H
            8'h59: r.code = 5'd21;  // Y
            8'h50: r.code = 5'd22;  // P
            8'h51: r.code = 5'd23;  // Q
            8'h4F: r.code = 5'd24;  // O
            8'h42: r.code = 5'd25;  // B
            8'h47: r.code = 5'd26;  // G
            8'h4D: r.code = 5'd28;  // M
            8'h58: r.code = 5'd29;  // X
            8'h56: r.code = 5'd30;  // V
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // figures tables, inverted; ita2 selects the international set
    function automatic t_look find_figure(input logic [7:0] ch, input logic ita2);
        t_look r;
        r.hit  = 1'b1;
        r.code = 5'd0;
        case (ch)
            8'h33: r.code = 5'd1;   // 3
            8'h0A: r.code = 5'd2;
            8'h2D: r.code = 5'd3;   // -
            8'h20: r.code = 5'd4;
            8'h07: r.code = ita2 ? 5'd11 : 5'd5;   // bell
            8'h27: r.code = ita2 ? 5'd5 : 5'd11;   // apostrophe
            8'h38: r.code = 5'd6;   // 8
            8'h37: r.code = 5'd7;   // 7
            8'h0D: r.code = 5'd8;
            8'h24: begin            // dollar, us set only
                r.hit  = !ita2;
                r.code = 5'd9;
            end
            8'h05: begin            // enquiry, ita2 set only
                r.hit  = ita2;
                r.code = 5'd9;
            end
            8'h34: r.code = 5'd10;  // 4
            8'h2C: r.code = 5'd12;  // comma
            8'h21: r.code = 5'd13;  // !
            8'h3A: r.code = 5'd14;  // :
            8'h28: r.code = 5'd15;  // (
            8'h35: r.code = 5'd16;  // 5
            8'h22: r.code = 5'd17;  // double quote
            8'h29: r.code = 5'd18;  // )
            8'h32: r.code = 5'd19;  // 2
            8'h23: begin            // hash, us set only
                r.hit  = !ita2;
                r.code = 5'd20;
            end
            8'h36: r.code = 5'd21;  // 6
            8'h30: r.code = 5'd22;  // 0
            8'h31: r.code = 5'd23;  // 1
            8'h39: r.code = 5'd24;  // 9
            8'h3F: r.code = 5'd25;  // ?
            8'h26: r.code = 5'd26;  // &
            8'h2E: r.code = 5'd28;  // .
            8'h2F: r.code = 5'd29;  // /
            8'h3B: r.code = 5'd30;  // ;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/baudot_shift_encoder.sv =====
// Baudot shift encoder: ascii bytes in, 5-bit ita2 codes out.
// Input channel: i_in_valid / o_in_stall with i_char_byte and i_message_start.
// Each byte may give no code (unknown byte), one code, or a FIGS/LTRS shift
// code followed by the character code; o_last marks the final code of a byte
// and o_shift_after gives the tracked case after each code.
// Output channel: o_out_valid / i_out_stall with o_baudot_code, o_last and
// o_shift_after, read from a four-entry output queue.
// Path: a byte waits in the input register, and its codes are then written into
// the output queue, which shows the first of them on the output port.
// Throughput: one byte per cycle while each gives at most one code and the
// receiver does not stall; the output port moves one code per cycle.
// The input register takes a new byte whenever the queue holds two or fewer
// codes, so a stalled receiver backs up into o_in_stall at three codes.
// Configuration: write figures_set (index 0) and start_shift (index 1) through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Reset (synchronous, active low) clears both registers, sets the tracked
// case to letters and empties the input register and the output queue.
module baudot_shift_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_message_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_baudot_code,
    output logic       o_last,
    output logic       o_shift_after
);

    bse_pkg::t_push push;
    bse_pkg::t_res  res;
    logic           room;

    // input register, lookup and case tracking
    bse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_byte     (i_char_byte),
        .i_message_start (i_message_start),
        .i_room          (room),
        .o_push          (push)
    );

    // output queue
    bse_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_baudot_code = res.code;
    assign o_last        = res.last;
    assign o_shift_after = res.shift_after;

endmodule

// ===== src/bse_front.sv =====
module bse_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic                     i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_char_byte,
    input  logic                     i_message_start,
    input  logic                     i_room,
    output bse_pkg::t_push           o_push
);

    logic       r_figures_set;
    logic       r_start_shift;
    logic       r_case;
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_msg;

    logic           n_case;
    logic           fire;
    logic           cur;
    logic [7:0]     ch;
    bse_pkg::t_look lt;
    bse_pkg::t_look fg;
    logic           found;
    logic [4:0]     code;
    logic           need;
    logic           neutral;
    logic           shift;
    logic           final_case;
    bse_pkg::t_res  char_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_figures_set <= 1'b0;
            r_start_shift <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bse_pkg::CFG_FIGURES_SET) begin
                r_figures_set <= i_cfg_data;
            end else begin
                r_start_shift <= i_cfg_data;
            end
        end
    end

    // item is encoded once the queue has room for two codes
    assign fire       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_char <= i_char_byte;
            r_msg  <= i_message_start;
        end
    end

    // fold case and look the byte up
    always_comb begin
        cur = r_msg ? r_start_shift : r_case;
        ch  = r_char;
        if (r_char >= 8'h61 && r_char <= 8'h7A) begin
            ch = r_char - 8'd32;
        end
        lt      = bse_pkg::find_letter(ch);
        fg      = bse_pkg::find_figure(ch, r_figures_set);
        found   = lt.hit || fg.hit;
        code    = lt.hit ? lt.code : fg.code;
        need    = lt.hit ? bse_pkg::CASE_LTRS : bse_pkg::CASE_FIGS;
        neutral = (code == bse_pkg::CODE_SPACE) || (code == bse_pkg::CODE_CR) ||
                  (code == bse_pkg::CODE_LF);
        shift   = !neutral && (need != cur);
        if (code == bse_pkg::CODE_SPACE) begin
            final_case = bse_pkg::CASE_LTRS;
        end else if (shift) begin
            final_case = need;
        end else begin
            final_case = cur;
        end
        n_case = found ? final_case : cur;
    end

    // tracked case
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case <= bse_pkg::CASE_LTRS;
        end else if (fire) begin
            r_case <= n_case;
        end
    end

    // codes for the output queue
    always_comb begin
        char_res.code        = code;
        char_res.last        = 1'b1;
        char_res.shift_after = final_case;
        o_push.valid  = fire && found;
        o_push.two    = shift;
        o_push.second = char_res;
        if (shift) begin
            o_push.first.code        = need ? bse_pkg::CODE_FIGS : bse_pkg::CODE_LTRS;
            o_push.first.last        = 1'b0;
            o_push.first.shift_after = need;
        end else begin
            o_push.first = char_res;
        end
    end

endmodule

// ===== src/bse_outq.sv =====
module bse_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bse_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bse_pkg::t_res  o_res
);

    logic [bse_pkg::PTR_W-1:0] r_wr;
    logic [bse_pkg::PTR_W-1:0] r_rd;
    logic [bse_pkg::CNT_W-1:0] r_cnt;
    bse_pkg::t_res             r_mem [bse_pkg::QUEUE_DEPTH];

    logic                      pop;
    logic [bse_pkg::CNT_W-1:0] n_cnt;
    logic [bse_pkg::PTR_W-1:0] wr_next;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_res       = r_mem[r_rd];
    assign wr_next     = r_wr + bse_pkg::PTR_W'(1);

    // room for a full pair of codes
    assign o_room = (r_cnt <= bse_pkg::CNT_W'(bse_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_cnt = n_cnt + (i_push.two ? bse_pkg::CNT_W'(2) : bse_pkg::CNT_W'(1));
        end
        if (pop) begin
            n_cnt = n_cnt - bse_pkg::CNT_W'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + bse_pkg::PTR_W'(1);
            end
            if (i_push.valid) begin
                r_wr <= i_push.two ? wr_next + bse_pkg::PTR_W'(1) : wr_next;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.first;
            if (i_push.two) begin
                r_mem[wr_next] <= i_push.second;
            end
        end
    end

endmodule

// ===== src/bse_checker.sv =====
module bse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_baudot_code,
    input logic       o_last,
    input logic       o_shift_after
);

    // reset empties both sides
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // a code that is not last is a shift code agreeing with the new case
    a_shift_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |->
            (o_baudot_code == bse_pkg::CODE_FIGS && o_shift_after) ||
            (o_baudot_code == bse_pkg::CODE_LTRS && !o_shift_after))
        else $error("bad shift code");

    // the character code follows its shift code at once
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall |=> o_out_valid && o_last)
        else $error("character code missing after shift code");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_baudot_code) && $stable(o_last) &&
            $stable(o_shift_after))
        else $error("stalled output changed");

endmodule

bind baudot_shift_encoder bse_checker u_bse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_baudot_code (o_baudot_code),
    .o_last        (o_last),
    .o_shift_after (o_shift_after)
);

// ===== dv/baudot_shift_encoder_tb.sv =====
`timescale 1ns / 100ps

module baudot_shift_encoder_tb;

    // quiet cycles allowed before the run is called hung
    localparam int STALL_LIMIT = 5000;
    // cycles to let the pipeline drain after the last expected code
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    // tracks the shift state and holds the codes still owed by the block
    class code_tracker;
        logic figs_ita2;
        logic start_figs;
        logic cur_case;
        byte unsigned letters_rom[32];
        byte unsigned figs_us_rom[32];
        byte unsigned figs_ita2_rom[32];
        bse_pkg::t_res pending_codes[$];
        int errors;

        function new();
            letters_rom = '{
                8'h00, "E",   8'h0A, "A",   " ",   "S",   "I",   "U",
                8'h0D, "D",   "R",   "J",   "N",   "F",   "C",   "K",
                "T",   "Z",   "L",   "W",   "H",   "Y",   "P",   "Q",
                "O",   "B",   "G",   8'h00, "M",   "X",   "V",   8'h00
            };
            figs_us_rom = '{
                8'h00, "3",   8'h0A, "-",   " ",   8'h07, "8",   "7",
                8'h0D, "$",   "4",   "'",   ",",   "!",   ":",   "(",
                "5",   "\"",  ")",   "2",   "#",   "6",   "0",   "1",
                "9",   "?",   "&",   8'h00, ".",   "/",   ";",   8'h00
            };
            figs_ita2_rom = '{
                8'h00, "3",   8'h0A, "-",   " ",   "'",   "8",   "7",
                8'h0D, 8'h05, "4",   8'h07, ",",   "!",   ":",   "(",
                "5",   "\"",  ")",   "2",   8'h00, "6",   "0",   "1",
                "9",   "?",   "&",   8'h00, ".",   "/",   ";",   8'h00
            };
            figs_ita2  = 1'b0;
            start_figs = bse_pkg::CASE_LTRS;
            cur_case   = bse_pkg::CASE_LTRS;
            errors     = 0;
        endfunction

        // lowest code whose table entry equals ch; blank entries never match
        function int code_of(bit figures, logic [7:0] ch);
            byte unsigned entry;
            for (int i = 0; i < 32; i++) begin
                if (!figures)
                    entry = letters_rom[i];
                else if (figs_ita2)
                    entry = figs_ita2_rom[i];
                else
                    entry = figs_us_rom[i];
                if (entry != 8'h00 && entry == ch)
                    return i;
            end
            return -1;
        endfunction

        // accepted input transaction: queue the codes it must produce
        function int note_char(logic [7:0] ch, logic msg_start);
            logic [7:0]    folded;
            int            idx;
            logic          need;
            logic [4:0]    code;
            bse_pkg::t_res r;
            int            n;
            n = 0;
            if (msg_start)
                cur_case = start_figs;
            folded = ch;
            if (ch >= 8'h61 && ch <= 8'h7A)
                folded = ch - 8'd32;
            need = bse_pkg::CASE_LTRS;
            idx = code_of(1'b0, folded);
            if (idx < 0) begin
                need = bse_pkg::CASE_FIGS;
                idx = code_of(1'b1, folded);
            end
            if (idx < 0)
                return 0;
            code = 5'(idx);
            // shift code first when the character needs the other case
            if (code != bse_pkg::CODE_SPACE && code != bse_pkg::CODE_CR &&
                code != bse_pkg::CODE_LF && need != cur_case) begin
                cur_case = need;
                r.code = (need == bse_pkg::CASE_FIGS) ? bse_pkg::CODE_FIGS :
                                                        bse_pkg::CODE_LTRS;
                r.last = 1'b0;
                r.shift_after = cur_case;
                pending_codes.insert(pending_codes.size(), r);
                n = 1;
            end
            // space always returns to letters
            if (code == bse_pkg::CODE_SPACE)
                cur_case = bse_pkg::CASE_LTRS;
            r.code = code;
            r.last = 1'b1;
            r.shift_after = cur_case;
            pending_codes.insert(pending_codes.size(), r);
            return n + 1;
        endfunction

        // accepted output transaction: compare with the oldest owed code
        function void check_code(logic [4:0] code, logic last, logic shift_after);
            bse_pkg::t_res e;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected code %0d (last %0b shift %0b)",
                         $time, code, last, shift_after);
                errors++;
                return;
            end
            e = pending_codes.pop_front();
            if (code !== e.code) begin
                $display("%0t: baudot_code expected %0d got %0d", $time, e.code, code);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0b got %0b", $time, e.last, last);
                errors++;
            end
            if (shift_after !== e.shift_after) begin
                $display("%0t: shift_after expected %0b got %0b",
                         $time, e.shift_after, shift_after);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = bse_pkg::CFG_FIGURES_SET;
    logic       i_cfg_data = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_char_byte = 8'h00;
    logic       i_message_start = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [4:0] o_baudot_code;
    logic       o_last;
    logic       o_shift_after;

    code_tracker tracker;
    t_idle       idle_mode = IDLE_NONE;
    // figures characters of both sets, bell and enquiry included
    string       fig_chars = "0123456789-',.!:()\"?&/;$#\007\005";

    baudot_shift_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_byte     (i_char_byte),
        .i_message_start (i_message_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_baudot_code   (o_baudot_code),
        .o_last          (o_last),
        .o_shift_after   (o_shift_after)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 46;
            IDLE_BOTH: return $urandom_range(99) < 35;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 46;
            IDLE_BOTH: return $urandom_range(99) < 35;
            default:   return 1'b0;
        endcase
    endfunction

    // one input transaction, with random gaps ahead of it
    task automatic send_char(logic [7:0] ch, logic msg_start, output int n);
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_char_byte     <= ch;
        i_message_start <= msg_start;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        n = tracker.note_char(ch, msg_start);
    endtask

    // wait until every owed code is back and the pipeline has emptied
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers on consecutive edges
    task automatic set_config(logic figs_ita2, logic start_figs);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bse_pkg::CFG_FIGURES_SET;
        i_cfg_data <= figs_ita2;
        @(posedge i_clk);
        tracker.figs_ita2 = figs_ita2;
        i_cfg_idx  <= bse_pkg::CFG_START_SHIFT;
        i_cfg_data <= start_figs;
        @(posedge i_clk);
        tracker.start_figs = start_figs;
        i_cfg_we <= 1'b0;
    endtask

    // runs of letters and figures with spaces and line breaks, plus noise bytes
    task automatic random_chars(int want);
        int         got;
        int         n;
        int         r;
        bit         fig_run;
        logic [7:0] ch;
        got = 0;
        fig_run = 1'b0;
        while (got < want) begin
            if ($urandom_range(99) < 20)
                fig_run = !fig_run;
            r = $urandom_range(99);
            if (r < 12) begin
                ch = 8'($urandom_range(255));
            end else if (r < 22) begin
                case ($urandom_range(2))
                    0: ch = 8'h20;
                    1: ch = 8'h0D;
                    default: ch = 8'h0A;
                endcase
            end else if (fig_run) begin
                ch = fig_chars[$urandom_range(fig_chars.len() - 1)];
            end else begin
                ch = 8'h41 + 8'($urandom_range(25));
                if ($urandom_range(1) == 1)
                    ch = ch + 8'h20;
            end
            send_char(ch, $urandom_range(99) < 5, n);
            if (n > 0)
                got++;
        end
    endtask

    // output side: check each accepted transaction, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                tracker.check_code(o_baudot_code, o_last, o_shift_after);
            i_out_stall <= receiver_stalls();
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[baudot_shift_encoder] ERROR");
        $finish;
    end

    // main sequence
    initial begin
        int n;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: us figures, message start in figures
        set_config(1'b0, bse_pkg::CASE_FIGS);
        send_char("A", 1'b1, n);     // start in figures, needs a letters shift
        send_char("a", 1'b0, n);     // lower case folds
        send_char("z", 1'b0, n);
        send_char("3", 1'b0, n);     // figures shift
        send_char(" ", 1'b0, n);     // space drops to letters, no shift
        send_char("$", 1'b0, n);
        send_char(8'h0D, 1'b0, n);   // carriage return keeps figures
        send_char(8'h0A, 1'b0, n);
        send_char("#", 1'b0, n);
        send_char(8'h07, 1'b0, n);   // bell
        send_char("'", 1'b0, n);
        send_char(8'h05, 1'b0, n);   // enquiry, unknown in the us set
        send_char(8'h00, 1'b0, n);   // blank entries never match
        send_char(8'hFF, 1'b0, n);
        send_char(8'h80, 1'b0, n);
        send_char(8'hE1, 1'b0, n);   // high bytes are not folded
        send_char(8'h60, 1'b0, n);   // just outside the lower-case range
        send_char(8'h7B, 1'b0, n);
        send_char(8'h7F, 1'b1, n);   // unknown byte still loads the start case
        send_char("Q", 1'b0, n);
        send_char("e", 1'b1, n);
        send_char("?", 1'b0, n);
        send_char(";", 1'b0, n);
        send_char("M", 1'b0, n);

        // random phases over every idling mode and register setting
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            idle_mode = t_idle'(ph % 4);
            set_config(ph[2], ph[0]);
            random_chars(210);
        end
        wait_idle();

        if (tracker.errors == 0)
            $display("[baudot_shift_encoder] OK");
        else
            $display("[baudot_shift_encoder] ERROR");
        $finish;
    end

endmodule
